### hw/rtl/dsit_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsit_pkg
// Shared types, constants and the date check for the sorted date table.
// ----------------------------------------------------------------------------
package dsit_pkg;

   // Default sizes
   localparam int DEPTH_DEF       = 16;
   localparam int HANDLE_BITS_DEF = 16;

   // Field widths of a date
   localparam int YEAR_BITS   = 12;
   localparam int MONTH_BITS  = 4;
   localparam int DAY_BITS    = 5;
   localparam int KEY_BITS    = YEAR_BITS + MONTH_BITS + DAY_BITS;
   localparam int STATUS_BITS = 3;
   localparam int KIND_BITS   = 2;

   // Date limits
   localparam int YEAR_MIN  = 2000;
   localparam int YEAR_MAX  = 3000;
   localparam int MONTH_MAX = 12;
   localparam int DAYS_LONG = 31;
   localparam int DAYS_SHORT = 30;
   localparam int DAYS_FEB  = 29;

   // Month codes with special day limits
   localparam logic [MONTH_BITS-1:0] MON_FEB = 4'd2;
   localparam logic [MONTH_BITS-1:0] MON_APR = 4'd4;
   localparam logic [MONTH_BITS-1:0] MON_JUN = 4'd6;
   localparam logic [MONTH_BITS-1:0] MON_SEP = 4'd9;
   localparam logic [MONTH_BITS-1:0] MON_NOV = 4'd11;

   // Request type carried in tuser
   localparam logic REQ_ADD  = 1'b0;
   localparam logic REQ_LIST = 1'b1;

   typedef enum logic [STATUS_BITS-1:0] {
      STAT_OK        = 3'd0,
      STAT_BAD_MONTH = 3'd1,
      STAT_BAD_DAY   = 3'd2,
      STAT_BAD_YEAR  = 3'd3,
      STAT_FULL      = 3'd4
   } status_type;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_STATUS = 2'd0,
      KIND_ENTRY  = 2'd1,
      KIND_EMPTY  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_ADD,
      S_LIST,
      S_FIN
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;     // latch the accepted request
      logic add_commit;  // insert (if room) and load the add status
      logic scan_clear;  // restart the list scan
      logic scan_step;   // rotate the cell chain by one
      logic pend_load;   // take cell 0 into the pending entry
      logic pend_push;   // send the pending entry, not last
      logic out_final;   // send the closing response of a list
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_list;
      logic rsp_free;
      logic hit;
      logic pend_valid;
      logic scan_done;
   } sts_type;

   // Date check in the fixed order month, day, year
   function automatic status_type check_date(
      input logic [YEAR_BITS-1:0]  year,
      input logic [MONTH_BITS-1:0] month,
      input logic [DAY_BITS-1:0]   day
   );
      logic [DAY_BITS-1:0] lim;
      if ((month == MON_FEB)) begin
         lim = DAY_BITS'(DAYS_FEB);
      end else if ((month == MON_APR) || (month == MON_JUN) ||
                   (month == MON_SEP) || (month == MON_NOV)) begin
         lim = DAY_BITS'(DAYS_SHORT);
      end else begin
         lim = DAY_BITS'(DAYS_LONG);
      end
      priority if ((month == '0) || (month > MONTH_BITS'(MONTH_MAX))) begin
         return STAT_BAD_MONTH;
      end else if (day > lim) begin
         return STAT_BAD_DAY;
      end else if ((year < YEAR_BITS'(YEAR_MIN)) || (year > YEAR_BITS'(YEAR_MAX))) begin
         return STAT_BAD_YEAR;
      end else begin
         return STAT_OK;
      end
   endfunction

endpackage
`default_nettype wire

### hw/rtl/date_sorted_insert_table_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// date_sorted_insert_table_core
// Table of dated entries kept in ascending date order.
// ----------------------------------------------------------------------------
// An add request (tuser 0) checks the date, stores a failed date as a null
// 0/0/0 entry, inserts it (if there is room) in front of equal dates across
// all cells in parallel, and returns one status response. A list request
// (tuser 1) walks the table by rotating the cell chain one position per
// cycle, unless a response stall holds it; each non-null entry is sent in
// order and the last one carries tlast, or a single "empty" response comes
// back. Requests are taken one at a time.
module date_sorted_insert_table_core #(
   parameter int DEPTH       = dsit_pkg::DEPTH_DEF,
   parameter int HANDLE_BITS = dsit_pkg::HANDLE_BITS_DEF,
   localparam int IN_W  = ((dsit_pkg::KEY_BITS + HANDLE_BITS + 7) / 8) * 8,
   localparam int OUT_W = ((dsit_pkg::STATUS_BITS + dsit_pkg::KEY_BITS +
                            HANDLE_BITS + 7) / 8) * 8
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   input  wire  [IN_W-1:0]      req_tdata,   // year, month, day, desc_handle
   input  wire  [0:0]           req_tuser,   // req_type
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   output logic [OUT_W-1:0]     rsp_tdata,   // status, out_year, out_month,
                                             // out_day, out_handle
   output logic [dsit_pkg::KIND_BITS-1:0] rsp_tuser,  // kind
   output logic                 rsp_tlast
);

   dsit_pkg::cmd_type cmd;
   dsit_pkg::sts_type sts;

   dsit_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   dsit_datapath #(
      .DEPTH       (DEPTH),
      .HANDLE_BITS (HANDLE_BITS),
      .IN_W        (IN_W),
      .OUT_W       (OUT_W)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule
`default_nettype wire

### hw/rtl/dsit_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsit_ctrl
// Sequencer for add and list requests; drives the datapath by commands.
// ----------------------------------------------------------------------------
module dsit_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_tvalid,
   output logic                req_tready,
   input  dsit_pkg::sts_type   sts,
   output dsit_pkg::cmd_type   cmd
);

   dsit_pkg::state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dsit_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         dsit_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = dsit_pkg::S_DECODE;
            end
         end
         dsit_pkg::S_DECODE: begin
            if (sts.is_list) begin
               cmd.scan_clear = 1'b1;
               state_in       = dsit_pkg::S_LIST;
            end else begin
               state_in = dsit_pkg::S_ADD;
            end
         end
         dsit_pkg::S_ADD: begin
            if (sts.rsp_free) begin
               cmd.add_commit = 1'b1;
               state_in       = dsit_pkg::S_IDLE;
            end
         end
         dsit_pkg::S_LIST: begin
            // One cell per cycle; a hit with a pending entry needs the output
            if (sts.scan_done) begin
               state_in = dsit_pkg::S_FIN;
            end else if (!sts.hit) begin
               cmd.scan_step = 1'b1;
            end else if (!sts.pend_valid) begin
               cmd.pend_load = 1'b1;
               cmd.scan_step = 1'b1;
            end else if (sts.rsp_free) begin
               cmd.pend_push = 1'b1;
               cmd.pend_load = 1'b1;
               cmd.scan_step = 1'b1;
            end
         end
         dsit_pkg::S_FIN: begin
            if (sts.rsp_free) begin
               cmd.out_final = 1'b1;
               state_in      = dsit_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = dsit_pkg::S_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

### hw/rtl/dsit_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsit_datapath
// Sorted cell chain with parallel compare-and-shift insert, rotating list
// scan, pending entry and the response register.
// ----------------------------------------------------------------------------
module dsit_datapath #(
   parameter int DEPTH       = dsit_pkg::DEPTH_DEF,
   parameter int HANDLE_BITS = dsit_pkg::HANDLE_BITS_DEF,
   parameter int IN_W        = 40,
   parameter int OUT_W       = 40
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire  [IN_W-1:0]         req_tdata,
   input  wire  [0:0]              req_tuser,
   output logic                    rsp_tvalid,
   input  wire                     rsp_tready,
   output logic [OUT_W-1:0]        rsp_tdata,
   output logic [dsit_pkg::KIND_BITS-1:0] rsp_tuser,
   output logic                    rsp_tlast,
   input  dsit_pkg::cmd_type       cmd,
   output dsit_pkg::sts_type       sts
);

   localparam int YB = dsit_pkg::YEAR_BITS;
   localparam int MB = dsit_pkg::MONTH_BITS;
   localparam int DB = dsit_pkg::DAY_BITS;
   localparam int KB = dsit_pkg::KEY_BITS;
   localparam int SB = dsit_pkg::STATUS_BITS;
   localparam int HB = HANDLE_BITS;
   localparam int CW = $clog2(DEPTH + 1);

   // Field offsets in tdata
   localparam int IN_MON  = YB;
   localparam int IN_DAY  = YB + MB;
   localparam int IN_HND  = YB + MB + DB;
   localparam int OUT_YR  = SB;
   localparam int OUT_MON = SB + YB;
   localparam int OUT_DAY = SB + YB + MB;
   localparam int OUT_HND = SB + YB + MB + DB;

   // Captured request
   logic          list_ff;
   logic [YB-1:0] year_ff;
   logic [MB-1:0] month_ff;
   logic [DB-1:0] day_ff;
   logic [HB-1:0] handle_ff;

   // Cell chain, key is {year, month, day}
   logic [KB-1:0] key_ff  [DEPTH];
   logic [HB-1:0] hnd_ff  [DEPTH];
   logic          null_ff [DEPTH];
   logic [CW-1:0] count_ff;

   // List scan
   logic [CW-1:0] scan_ff;
   logic          pend_valid_ff;
   logic [KB-1:0] pend_key_ff;
   logic [HB-1:0] pend_hnd_ff;

   // Response register
   logic                          rsp_valid_ff;
   logic [OUT_W-1:0]              rsp_data_ff, rsp_data_in;
   logic [dsit_pkg::KIND_BITS-1:0] rsp_user_ff, rsp_user_in;
   logic                          rsp_last_ff, rsp_last_in;
   logic                          rsp_load;

   // Insert evaluation
   dsit_pkg::status_type add_stat;
   logic                 full;
   logic                 ins_en;
   logic [KB-1:0]        new_key;
   logic                 new_null;
   logic [DEPTH-1:0]     lt;
   logic [DEPTH-1:0]     prev_lt;

   // Request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         list_ff   <= req_tuser[0];
         year_ff   <= req_tdata[YB-1:0];
         month_ff  <= req_tdata[IN_MON +: MB];
         day_ff    <= req_tdata[IN_DAY +: DB];
         handle_ff <= req_tdata[IN_HND +: HB];
      end
   end

   // Status and new entry
   always_comb begin
      full     = (count_ff == CW'(DEPTH));
      add_stat = full ? dsit_pkg::STAT_FULL
                      : dsit_pkg::check_date(year_ff, month_ff, day_ff);
      new_null = (add_stat != dsit_pkg::STAT_OK);
      new_key  = new_null ? '0 : {year_ff, month_ff, day_ff};
      ins_en   = cmd.add_commit && !full;
   end

   // Per-cell strict earlier-than; true for a prefix of the chain
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         lt[i] = (CW'(i) < count_ff) && (key_ff[i] < new_key);
      end
      prev_lt = {lt[DEPTH-2:0], 1'b1};
   end

   // Cell chain: rotate for the scan, or keep / take new / shift for insert
   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         if (cmd.scan_step) begin
            key_ff[i]  <= key_ff[(i + 1) % DEPTH];
            hnd_ff[i]  <= hnd_ff[(i + 1) % DEPTH];
            null_ff[i] <= null_ff[(i + 1) % DEPTH];
         end else if (ins_en && !lt[i]) begin
            if (prev_lt[i]) begin
               key_ff[i]  <= new_key;
               hnd_ff[i]  <= handle_ff;
               null_ff[i] <= new_null;
            end else begin
               key_ff[i]  <= key_ff[(i + DEPTH - 1) % DEPTH];
               hnd_ff[i]  <= hnd_ff[(i + DEPTH - 1) % DEPTH];
               null_ff[i] <= null_ff[(i + DEPTH - 1) % DEPTH];
            end
         end
      end
   end

   // Fill count and scan position
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         scan_ff       <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         if (ins_en) begin
            count_ff <= count_ff + 1'b1;
         end
         if (cmd.scan_clear) begin
            scan_ff       <= '0;
            pend_valid_ff <= 1'b0;
         end else begin
            if (cmd.scan_step) begin
               scan_ff <= scan_ff + 1'b1;
            end
            if (cmd.pend_load) begin
               pend_valid_ff <= 1'b1;
            end
         end
      end
   end

   // Pending entry, held back until the next hit or the end of the scan
   always_ff @(posedge clock) begin
      if (cmd.pend_load) begin
         pend_key_ff <= key_ff[0];
         pend_hnd_ff <= hnd_ff[0];
      end
   end

   // Response selection
   always_comb begin
      rsp_load    = cmd.add_commit || cmd.pend_push || cmd.out_final;
      rsp_data_in = '0;
      rsp_user_in = dsit_pkg::KIND_STATUS;
      rsp_last_in = 1'b1;
      if (cmd.add_commit) begin
         rsp_data_in[SB-1:0] = add_stat;
      end else if (cmd.pend_push || pend_valid_ff) begin
         rsp_user_in                  = dsit_pkg::KIND_ENTRY;
         rsp_last_in                  = !cmd.pend_push;
         rsp_data_in[OUT_YR +: YB]    = pend_key_ff[KB-1 -: YB];
         rsp_data_in[OUT_MON +: MB]   = pend_key_ff[DB +: MB];
         rsp_data_in[OUT_DAY +: DB]   = pend_key_ff[DB-1:0];
         rsp_data_in[OUT_HND +: HB]   = pend_hnd_ff;
      end else begin
         rsp_user_in = dsit_pkg::KIND_EMPTY;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Status to the controller
   always_comb begin
      sts.is_list    = (list_ff == dsit_pkg::REQ_LIST);
      sts.rsp_free   = !rsp_valid_ff || rsp_tready;
      sts.hit        = (scan_ff < count_ff) && !null_ff[0];
      sts.pend_valid = pend_valid_ff;
      sts.scan_done  = (scan_ff == CW'(DEPTH));
   end

endmodule
`default_nettype wire

### hw/rtl/dsit_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsit_checker
// Port-level checks for the sorted date table, bound to the top level.
// ----------------------------------------------------------------------------
module dsit_checker #(
   parameter int OUT_W = 40
) (
   input wire                   clock,
   input wire                   reset,
   input wire                   req_tvalid,
   input wire                   req_tready,
   input wire                   rsp_tvalid,
   input wire                   rsp_tready,
   input wire [OUT_W-1:0]       rsp_tdata,
   input wire [dsit_pkg::KIND_BITS-1:0] rsp_tuser,
   input wire                   rsp_tlast
);

   localparam int SB = dsit_pkg::STATUS_BITS;

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   // The block is busy in the cycle after it takes a request
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken back to back");

   // Add status and empty-list responses close their request
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == dsit_pkg::KIND_STATUS ||
                     rsp_tuser == dsit_pkg::KIND_EMPTY) |-> rsp_tlast)
      else $error("single response without tlast");

   // Status responses carry a known code and no entry fields
   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == dsit_pkg::KIND_STATUS |->
         rsp_tdata[SB-1:0] <= dsit_pkg::STAT_FULL && (rsp_tdata >> SB) == '0)
      else $error("malformed status response");

   // Listed entries report status ok
   a_entry_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == dsit_pkg::KIND_ENTRY |->
         rsp_tdata[SB-1:0] == dsit_pkg::STAT_OK)
      else $error("listed entry with nonzero status");

endmodule

bind date_sorted_insert_table_core dsit_checker #(.OUT_W(OUT_W)) u_dsit_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire
